// ----- src/blht_pkg.sv -----
// Package for the bond length histogram trainer.
// Holds field widths, codes, sequencer states and the control structs
// shared by the arithmetic unit, the counter store and the top level.
`default_nettype none

package blht_pkg;

  localparam int COORD_W   = 20;
  localparam int SQ_W      = 40;
  localparam int SUM_W     = 42;
  localparam int ROOT_W    = 21;
  localparam int REM_W     = 24;
  localparam int COUNT_W   = 32;
  localparam int WIDTH_W   = 11;
  localparam int BINCNT_W  = 7;
  localparam int KIND_W    = 3;
  localparam int RBIN_W    = 6;
  localparam int CFG_IDX_W = 1;
  localparam int STEP_W    = 5;

  localparam int BOND_KINDS = 6;

  localparam logic [KIND_W-1:0]    KIND_GATED    = 3'd5;
  localparam logic [SUM_W-1:0]     GATE_LIMIT_SQ = 42'd589824;
  localparam logic [COUNT_W-1:0]   COUNT_MAX     = 32'hFFFF_FFFF;
  localparam logic [RBIN_W-1:0]    BIN_CLIP      = 6'd63;
  localparam logic [STEP_W-1:0]    MUL_LAST      = 5'd6;
  localparam logic [STEP_W-1:0]    STEP_LAST     = 5'(ROOT_W - 1);

  localparam logic               OP_ACCUM = 1'b0;
  localparam logic               OP_READ  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_BIN_WIDTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_COUNT = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SQRT,
    S_DINIT,
    S_DIV,
    S_LOOK,
    S_RMW
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic sqrt;
    logic div_init;
    logic div;
  } arith_cmd_t;

  typedef struct packed {
    logic rd;
    logic wr_obs;
    logic wr_ref;
  } store_cmd_t;

endpackage

`default_nettype wire

// ----- src/bond_length_histogram_trainer.sv -----
// Bond length histogram trainer: top level with sequencer, configuration
// registers and result register. Uses blht_pkg, blht_arith, blht_store.
//
// One request at a time. An accumulate request runs the squared differences
// in the shared multiplier, then 21 one-bit steps of the square root, the
// divider load and 21 one-bit steps of the divide by bin_width on the shared
// subtract/compare unit, then a read and an update of the counter memories.
// A read request reads the counter memories and registers the result. After
// reset a clearing sweep zeroes both counter memories, one entry a cycle, over
// the 6*MAX_BINS observed entries (384 by default); no request is accepted
// meanwhile. The result waits in an output register; a new request is
// accepted while it waits, and the block holds its next result until the
// register is free.
`default_nettype none

module bond_length_histogram_trainer import blht_pkg::*; #(
  parameter int MAX_BINS = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [WIDTH_W-1:0]         cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       operation,
  input  logic [KIND_W-1:0]          bond_kind,
  input  logic signed [COORD_W-1:0]  first_x,
  input  logic signed [COORD_W-1:0]  first_y,
  input  logic signed [COORD_W-1:0]  first_z,
  input  logic signed [COORD_W-1:0]  second_x,
  input  logic signed [COORD_W-1:0]  second_y,
  input  logic signed [COORD_W-1:0]  second_z,
  input  logic signed [COORD_W-1:0]  gate_x,
  input  logic signed [COORD_W-1:0]  gate_y,
  input  logic signed [COORD_W-1:0]  gate_z,
  input  logic [RBIN_W-1:0]          read_bin,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [RBIN_W-1:0]          bin_index,
  output logic                       counted,
  output logic                       out_of_range,
  output logic [COUNT_W-1:0]         observed_count,
  output logic [COUNT_W-1:0]         reference_count
);

  localparam int OBS_AW = $clog2(BOND_KINDS * MAX_BINS);
  localparam int REF_AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;

  state_t state;
  state_t state_next;
  logic [STEP_W-1:0] cnt;
  logic [STEP_W-1:0] cnt_next;

  logic [WIDTH_W-1:0]  bin_width;
  logic [BINCNT_W-1:0] bin_count;
  logic                op;
  logic [KIND_W-1:0]   kind;
  logic [RBIN_W-1:0]   rbin;

  arith_cmd_t          acmd;
  store_cmd_t          scmd;
  logic                accept;
  logic                out_free;
  logic                busy;
  logic [WIDTH_W-1:0]  divisor;
  logic [ROOT_W-1:0]   quotient;
  logic                gate_near;

  logic [ROOT_W-1:0]   bin;
  logic [ROOT_W-1:0]   bins_used;
  logic                kind_ok;
  logic                gate_ok;
  logic                in_mem;
  logic                hit;
  logic                drop;
  logic [OBS_AW-1:0]   obs_addr;
  logic [REF_AW-1:0]   ref_addr;
  logic [COUNT_W-1:0]  obs_rdata;
  logic [COUNT_W-1:0]  ref_rdata;
  logic [COUNT_W-1:0]  obs_inc;
  logic [COUNT_W-1:0]  ref_inc;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign divisor  = (bin_width == '0) ? WIDTH_W'(1) : bin_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_width <= WIDTH_W'(32);
      bin_count <= BINCNT_W'(48);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BIN_WIDTH: bin_width <= cfg_data;
        REG_BIN_COUNT: bin_count <= cfg_data[BINCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept) state_next = (operation == OP_READ) ? S_LOOK : S_MUL;
      S_MUL:   if (cnt == MUL_LAST) state_next = S_SQRT;
      S_SQRT:  if (cnt == STEP_LAST) state_next = S_DINIT;
      S_DINIT: state_next = S_DIV;
      S_DIV:   if (cnt == STEP_LAST) state_next = S_LOOK;
      S_LOOK:  state_next = S_RMW;
      S_RMW:   if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
    cnt_next = (state_next != state) ? '0 : cnt + 1'b1;
  end

  always_comb begin
    in_ready      = (state == S_IDLE) && !busy;
    acmd.load     = accept;
    acmd.mul      = (state == S_MUL);
    acmd.sqrt     = (state == S_SQRT);
    acmd.div_init = (state == S_DINIT);
    acmd.div      = (state == S_DIV);
    scmd.rd       = (state == S_LOOK);
    scmd.wr_obs   = (state == S_RMW) && out_free && hit;
    scmd.wr_ref   = (state == S_RMW) && out_free && hit;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op   <= operation;
      kind <= bond_kind;
      rbin <= read_bin;
    end
  end

  blht_arith u_arith (
    .clk       (clk),
    .cmd       (acmd),
    .idx       (cnt[2:0]),
    .first_pt  ({first_z, first_y, first_x}),
    .second_pt ({second_z, second_y, second_x}),
    .gate_pt   ({gate_z, gate_y, gate_x}),
    .divisor   (divisor),
    .quotient  (quotient),
    .gate_near (gate_near)
  );

  always_comb begin
    bin       = (op == OP_READ) ? ROOT_W'(rbin) : quotient;
    bins_used = (ROOT_W'(bin_count) < ROOT_W'(MAX_BINS)) ? ROOT_W'(bin_count)
                                                          : ROOT_W'(MAX_BINS);
    kind_ok   = (kind < KIND_W'(BOND_KINDS));
    gate_ok   = (kind != KIND_GATED) || gate_near;
    in_mem    = (bin < ROOT_W'(MAX_BINS));
    hit       = (op == OP_ACCUM) && kind_ok && gate_ok && (bin < bins_used);
    drop      = (op == OP_ACCUM) && kind_ok && gate_ok && !(bin < bins_used);
    ref_addr  = bin[REF_AW-1:0];
    obs_addr  = OBS_AW'(int'(kind) * MAX_BINS + int'(ref_addr));
    obs_inc   = (obs_rdata == COUNT_MAX) ? obs_rdata : obs_rdata + 1'b1;
    ref_inc   = (ref_rdata == COUNT_MAX) ? ref_rdata : ref_rdata + 1'b1;
  end

  blht_store #(
    .MAX_BINS (MAX_BINS)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .busy      (busy),
    .cmd       (scmd),
    .obs_addr  (obs_addr),
    .ref_addr  (ref_addr),
    .obs_wdata (obs_inc),
    .ref_wdata (ref_inc),
    .obs_rdata (obs_rdata),
    .ref_rdata (ref_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_RMW) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_RMW) && out_free) begin
      bin_index       <= (bin > ROOT_W'(BIN_CLIP)) ? BIN_CLIP : bin[RBIN_W-1:0];
      counted         <= hit;
      out_of_range    <= drop;
      observed_count  <= (kind_ok && in_mem) ? (hit ? obs_inc : obs_rdata) : '0;
      reference_count <= in_mem ? (hit ? ref_inc : ref_rdata) : '0;
    end
  end

  a_one_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(counted && out_of_range))
    else $error("result both counted and dropped");

  a_counted_bin: assert property (@(posedge clk) disable iff (rst)
    (out_valid && counted) |-> (BINCNT_W'(bin_index) < bin_count))
    else $error("counted bin beyond bin count");

  a_counted_nonzero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && counted) |-> (observed_count != '0 && reference_count != '0))
    else $error("counted result shows a zero counter");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("request accepted while one is in progress");

endmodule

`default_nettype wire

// ----- src/blht_arith.sv -----
// Shared arithmetic unit: one multiplier for the squared axis differences
// and one subtract/compare unit shared by the square root and the divide.
// Depends on blht_pkg.
`default_nettype none

module blht_arith import blht_pkg::*; (
  input  logic                         clk,
  input  arith_cmd_t                   cmd,
  input  logic [2:0]                   idx,
  input  logic [2:0][COORD_W-1:0]      first_pt,
  input  logic [2:0][COORD_W-1:0]      second_pt,
  input  logic [2:0][COORD_W-1:0]      gate_pt,
  input  logic [WIDTH_W-1:0]           divisor,
  output logic [ROOT_W-1:0]            quotient,
  output logic                         gate_near
);

  logic [2:0][COORD_W-1:0] pa;
  logic [2:0][COORD_W-1:0] pb;
  logic [2:0][COORD_W-1:0] pg;

  logic [SQ_W-1:0]   prod;
  logic [2:0]        prod_idx;
  logic              prod_ok;
  logic [SUM_W-1:0]  dist_sum;
  logic [SUM_W-1:0]  gate_sum;
  logic [ROOT_W-1:0] root;
  logic [ROOT_W-1:0] quo;
  logic [REM_W-1:0]  rem;

  logic signed [COORD_W:0] diff;
  logic [COORD_W-1:0]      mag;
  logic [COORD_W-1:0]      op_a;
  logic [COORD_W-1:0]      op_b;

  logic [REM_W-1:0]  sub_a;
  logic [REM_W-1:0]  sub_b;
  logic [REM_W:0]    sub_d;
  logic              sub_ge;
  logic [REM_W-1:0]  sqrt_rs;
  logic [WIDTH_W:0]  div_rs;

  always_comb begin
    op_a = pa[0];
    op_b = pb[0];
    case (idx)
      3'd0: begin op_a = pa[0]; op_b = pb[0]; end
      3'd1: begin op_a = pa[1]; op_b = pb[1]; end
      3'd2: begin op_a = pa[2]; op_b = pb[2]; end
      3'd3: begin op_a = pa[0]; op_b = pg[0]; end
      3'd4: begin op_a = pa[1]; op_b = pg[1]; end
      3'd5: begin op_a = pa[2]; op_b = pg[2]; end
      default: begin op_a = pa[0]; op_b = pa[0]; end
    endcase
    diff = {op_a[COORD_W-1], op_a} - {op_b[COORD_W-1], op_b};
    mag  = diff[COORD_W] ? COORD_W'(-diff) : diff[COORD_W-1:0];
  end

  assign sqrt_rs = {rem[REM_W-3:0], dist_sum[SUM_W-1:SUM_W-2]};
  assign div_rs  = {rem[WIDTH_W-1:0], quo[ROOT_W-1]};

  always_comb begin
    if (cmd.div) begin
      sub_a = REM_W'(div_rs);
      sub_b = REM_W'(divisor);
    end else begin
      sub_a = sqrt_rs;
      sub_b = REM_W'({root, 2'b01});
    end
    sub_d  = {1'b0, sub_a} - {1'b0, sub_b};
    sub_ge = !sub_d[REM_W];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pa       <= first_pt;
      pb       <= second_pt;
      pg       <= gate_pt;
      dist_sum <= '0;
      gate_sum <= '0;
      prod_ok  <= 1'b0;
      root     <= '0;
      rem      <= '0;
    end else if (cmd.mul) begin
      prod     <= SQ_W'(mag) * SQ_W'(mag);
      prod_idx <= idx;
      prod_ok  <= (idx < 3'd6);
      if (prod_ok) begin
        if (prod_idx < 3'd3) begin
          dist_sum <= dist_sum + SUM_W'(prod);
        end else begin
          gate_sum <= gate_sum + SUM_W'(prod);
        end
      end
    end else if (cmd.sqrt) begin
      dist_sum <= {dist_sum[SUM_W-3:0], 2'b00};
      rem      <= sub_ge ? sub_d[REM_W-1:0] : sqrt_rs;
      root     <= {root[ROOT_W-2:0], sub_ge};
    end else if (cmd.div_init) begin
      quo <= root;
      rem <= '0;
    end else if (cmd.div) begin
      rem <= sub_ge ? sub_d[REM_W-1:0] : REM_W'(div_rs);
      quo <= {quo[ROOT_W-2:0], sub_ge};
    end
  end

  assign quotient  = quo;
  assign gate_near = (gate_sum < GATE_LIMIT_SQ);

endmodule

`default_nettype wire

// ----- src/blht_store.sv -----
// Counter store: per-kind observed counters and shared reference counters,
// with a clearing sweep after reset. Depends on blht_pkg.
`default_nettype none

module blht_store import blht_pkg::*; #(
  parameter  int MAX_BINS = 64,
  localparam int OBS_DEPTH = BOND_KINDS * MAX_BINS,
  localparam int OBS_AW = $clog2(OBS_DEPTH),
  localparam int REF_AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1
) (
  input  logic               clk,
  input  logic               rst,
  output logic               busy,
  input  store_cmd_t         cmd,
  input  logic [OBS_AW-1:0]  obs_addr,
  input  logic [REF_AW-1:0]  ref_addr,
  input  logic [COUNT_W-1:0] obs_wdata,
  input  logic [COUNT_W-1:0] ref_wdata,
  output logic [COUNT_W-1:0] obs_rdata,
  output logic [COUNT_W-1:0] ref_rdata
);

  logic [COUNT_W-1:0] obs_mem [OBS_DEPTH];
  logic [COUNT_W-1:0] ref_mem [MAX_BINS];
  logic [OBS_AW-1:0]  clr_addr;
  logic               clr_ref;

  assign clr_ref = (clr_addr < OBS_AW'(MAX_BINS));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == OBS_AW'(OBS_DEPTH - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      obs_mem[clr_addr] <= '0;
    end else if (cmd.wr_obs) begin
      obs_mem[obs_addr] <= obs_wdata;
    end
    if (cmd.rd) begin
      obs_rdata <= obs_mem[obs_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      if (clr_ref) begin
        ref_mem[clr_addr[REF_AW-1:0]] <= '0;
      end
    end else if (cmd.wr_ref) begin
      ref_mem[ref_addr] <= ref_wdata;
    end
    if (cmd.rd) begin
      ref_rdata <= ref_mem[ref_addr];
    end
  end

endmodule

`default_nettype wire
